@@ design/kwhm_pkg.sv @@
// Package with the types, constants and codes shared by the k-way heap merge unit.
package kwhm_pkg;

    localparam int LISTS      = 8;
    localparam int DEPTH      = 256;
    localparam int LIST_BITS  = $clog2(LISTS);
    localparam int ENTRY_BITS = $clog2(DEPTH);
    localparam int COUNT_BITS = $clog2(DEPTH + 1);
    localparam int ADDR_BITS  = LIST_BITS + ENTRY_BITS;
    localparam int CFG_BITS   = 4;
    localparam int VALUE_W    = 32;
    localparam int INDEX_W    = 3;

    localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(LISTS);

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_START = 2'd1,
        ACT_POP   = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [0:0] {
        ST_VALID     = 1'b0,
        ST_EXHAUSTED = 1'b1
    } status_t;

    typedef struct packed {
        action_t             action;
        logic [INDEX_W-1:0]  list_index;
        logic signed [VALUE_W-1:0] element_value;
    } command_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] merged_value;
        logic [INDEX_W-1:0]  source_list;
        status_t             status;
    } result_t;

    typedef struct packed {
        logic load;
        logic seed_init;
        logic seed_rd;
        logic seed_wr;
        logic pop_empty;
        logic scan_init;
        logic scan_step;
        logic emit;
        logic refill;
    } dp_cmd_t;

    typedef struct packed {
        logic merging;
        logic any_head;
        logic cnt_last;
        logic more;
    } dp_sts_t;

endpackage

@@ design/kwhm_ctrl.sv @@
// Controller state machine that sequences loads, heap seeding, scans and refills.
module kwhm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  kwhm_pkg::action_t action,
    input  kwhm_pkg::dp_sts_t sts,
    output kwhm_pkg::dp_cmd_t cmd,
    output logic              busy
);
    import kwhm_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SEED_RD = 6'b000010,
        S_SEED_WR = 6'b000100,
        S_SCAN    = 6'b001000,
        S_EMIT    = 6'b010000,
        S_REFILL  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (action)
                        ACT_LOAD:  cmd.load = 1'b1;
                        ACT_START:
                        begin
                            cmd.seed_init = 1'b1;
                            state_next    = S_SEED_RD;
                        end
                        ACT_POP:
                        begin
                            if (!sts.merging || !sts.any_head)
                            begin
                                cmd.pop_empty = 1'b1;
                            end
                            else
                            begin
                                cmd.scan_init = 1'b1;
                                state_next    = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SEED_RD:
            begin
                cmd.seed_rd = 1'b1;
                state_next  = S_SEED_WR;
            end
            S_SEED_WR:
            begin
                cmd.seed_wr = 1'b1;
                state_next  = sts.cnt_last ? S_IDLE : S_SEED_RD;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.cnt_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = sts.more ? S_REFILL : S_IDLE;
            end
            S_REFILL:
            begin
                cmd.refill = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

@@ design/kwhm_datapath.sv @@
// Datapath with the element memory, per-list heads, counters and the minimum scan.
module kwhm_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  kwhm_pkg::dp_cmd_t               cmd,
    input  kwhm_pkg::command_t              command,
    input  logic [kwhm_pkg::CFG_BITS-1:0]   lists_in_use,
    output kwhm_pkg::dp_sts_t               sts,
    output logic                            result_valid,
    output kwhm_pkg::result_t               result
);
    import kwhm_pkg::*;

    logic signed [VALUE_W-1:0] mem [LISTS*DEPTH];
    logic signed [VALUE_W-1:0] rdata_reg;

    logic [COUNT_BITS-1:0] len_reg [LISTS];
    logic [COUNT_BITS-1:0] pos_reg [LISTS];
    logic [LISTS-1:0]      head_ok_reg;
    logic signed [VALUE_W-1:0] head_val_reg [LISTS];
    logic                  merging_reg;
    logic [LIST_BITS-1:0]  cnt_reg;
    logic                  best_ok_reg;
    logic [LIST_BITS-1:0]  best_reg;
    logic signed [VALUE_W-1:0] best_val_reg;
    logic                  result_valid_reg;
    result_t               result_reg;

    logic [LIST_BITS-1:0]  sel;
    logic [COUNT_BITS-1:0] len_sel;
    logic [COUNT_BITS-1:0] pos_inc;
    logic [CFG_BITS-1:0]   lists_eff;
    logic                  load_ok;
    logic                  take;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic [ADDR_BITS-1:0]  wr_addr;

    always_comb
    begin
        priority if (cmd.load)
        begin
            sel = command.list_index[LIST_BITS-1:0];
        end
        else if (cmd.seed_wr || cmd.scan_step)
        begin
            sel = cnt_reg;
        end
        else
        begin
            sel = best_reg;
        end
    end

    assign len_sel = len_reg[sel];
    assign pos_inc = pos_reg[sel] + COUNT_BITS'(1);
    assign load_ok = !merging_reg && (len_sel < COUNT_BITS'(DEPTH));
    assign wr_addr = {sel, len_sel[ENTRY_BITS-1:0]};
    assign rd_addr = cmd.seed_rd ? {cnt_reg, ENTRY_BITS'(0)}
                                 : {sel, pos_inc[ENTRY_BITS-1:0]};

    always_comb
    begin
        priority if (lists_in_use == '0)
        begin
            lists_eff = CFG_BITS'(1);
        end
        else if (lists_in_use > CFG_BITS'(LISTS))
        begin
            lists_eff = CFG_BITS'(LISTS);
        end
        else
        begin
            lists_eff = lists_in_use;
        end
    end

    assign take = head_ok_reg[cnt_reg] &&
                  (!best_ok_reg || (head_val_reg[cnt_reg] < best_val_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.load && load_ok)
        begin
            mem[wr_addr] <= command.element_value;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.seed_wr)
        begin
            head_val_reg[cnt_reg] <= rdata_reg;
        end
        if (cmd.refill)
        begin
            head_val_reg[best_reg] <= rdata_reg;
        end
        if (cmd.scan_step && take)
        begin
            best_reg     <= cnt_reg;
            best_val_reg <= head_val_reg[cnt_reg];
        end
        if (cmd.pop_empty)
        begin
            result_reg <= '{merged_value: '0, source_list: '0, status: ST_EXHAUSTED};
        end
        else if (cmd.emit)
        begin
            result_reg <= '{merged_value: best_val_reg,
                            source_list: INDEX_W'(best_reg), status: ST_VALID};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LISTS; i++)
            begin
                len_reg[i] <= '0;
                pos_reg[i] <= '0;
            end
            head_ok_reg      <= '0;
            merging_reg      <= 1'b0;
            cnt_reg          <= '0;
            best_ok_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.pop_empty || cmd.emit;
            if (cmd.load && load_ok)
            begin
                len_reg[sel] <= len_sel + COUNT_BITS'(1);
            end
            if (cmd.seed_init)
            begin
                for (int i = 0; i < LISTS; i++)
                begin
                    pos_reg[i] <= '0;
                end
                head_ok_reg <= '0;
                merging_reg <= 1'b1;
                cnt_reg     <= '0;
            end
            if (cmd.seed_wr)
            begin
                head_ok_reg[cnt_reg] <= (CFG_BITS'(cnt_reg) < lists_eff) && (len_sel != '0);
                cnt_reg              <= cnt_reg + LIST_BITS'(1);
            end
            if (cmd.pop_empty && merging_reg)
            begin
                merging_reg <= 1'b0;
                for (int i = 0; i < LISTS; i++)
                begin
                    len_reg[i] <= '0;
                    pos_reg[i] <= '0;
                end
            end
            if (cmd.scan_init)
            begin
                cnt_reg     <= '0;
                best_ok_reg <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                cnt_reg <= cnt_reg + LIST_BITS'(1);
                if (take)
                begin
                    best_ok_reg <= 1'b1;
                end
            end
            if (cmd.emit)
            begin
                pos_reg[sel] <= pos_inc;
                if (pos_inc >= len_sel)
                begin
                    head_ok_reg[sel] <= 1'b0;
                end
            end
        end
    end

    assign sts.merging  = merging_reg;
    assign sts.any_head = |head_ok_reg;
    assign sts.cnt_last = (cnt_reg == LIST_BITS'(LISTS - 1));
    assign sts.more     = (pos_inc < len_sel);

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ design/k_way_heap_merge_unit.sv @@
// Top level of the k-way heap merge unit.
// A load or an unused action is done in the idle state, and a pop on an empty or idle
// merge gives its exhausted item in the cycle after it is taken. A start passes through a
// seed read and a seed write state for each list to read that list's first element from
// the element memory, whose read is registered. A pop that finds a value scans the list
// heads one per cycle for the smallest value, the item appears on result for one cycle,
// and a refill state reloads the head from memory when that list has elements left. The
// receiver cannot stall; result_valid marks each result item for exactly one cycle.
module k_way_heap_merge_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  kwhm_pkg::command_t            command,
    output logic                          result_valid,
    output kwhm_pkg::result_t             result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kwhm_pkg::CFG_BITS-1:0] cfg_data
);
    import kwhm_pkg::*;

    logic [CFG_BITS-1:0] lists_in_use_reg;
    dp_cmd_t             cmd;
    dp_sts_t             sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lists_in_use_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            lists_in_use_reg <= cfg_data;
        end
    end

    kwhm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (command.action),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy)
    );

    kwhm_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .command      (command),
        .lists_in_use (lists_in_use_reg),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

@@ design/kwhm_checker.sv @@
// Port-level checker for the k-way heap merge unit and its bind statement.
module kwhm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input kwhm_pkg::command_t command,
    input logic               result_valid,
    input kwhm_pkg::result_t  result
);
    import kwhm_pkg::*;

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && command.action == ACT_START |=> busy)
        else $error("A start item did not begin seeding.");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && command.action != ACT_POP |=> !result_valid)
        else $error("A result item followed an item that is not a pop.");

    a_exhausted_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_EXHAUSTED |->
            result.merged_value == '0 && result.source_list == '0)
        else $error("An exhausted item carries a nonzero value or list.");

endmodule

bind k_way_heap_merge_unit kwhm_checker u_kwhm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .result_valid (result_valid),
    .result       (result)
);

@@ tb/tb_k_way_heap_merge_unit.sv @@
// Self-checking testbench for the k-way heap merge unit with its own merge predictor.
module tb_k_way_heap_merge_unit;
    import kwhm_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    command_t command = '0;
    logic result_valid;
    result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_BITS-1:0] cfg_data = '0;

    k_way_heap_merge_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .command(command),
        .result_valid(result_valid), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    command_t pending_items[$];
    result_t merged_expected[$];
    int idle_pct = 26;
    int mismatches = 0;
    int quiet_cycles = 0;

    logic signed [VALUE_W-1:0] list_store [LISTS][DEPTH];
    int list_len [LISTS];
    int read_pos [LISTS];
    bit merge_active = 1'b0;
    int merge_lists = LISTS;
    logic [CFG_BITS-1:0] lists_cfg = CFG_RESET;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic queue_item(input command_t c);
        pending_items = {pending_items, c};
    endtask

    task automatic merge_step(input command_t c);
        int best;
        result_t r;
        best = -1;
        r = '0;
        case (c.action)
            ACT_LOAD:
                if (!merge_active && list_len[c.list_index] < DEPTH)
                begin
                    list_store[c.list_index][list_len[c.list_index]] = c.element_value;
                    list_len[c.list_index]++;
                end
            ACT_START:
            begin
                merge_lists = (lists_cfg == 0) ? 1 : (lists_cfg > LISTS ? LISTS : lists_cfg);
                for (int i = 0; i < LISTS; i++)
                    read_pos[i] = 0;
                merge_active = 1'b1;
            end
            ACT_POP:
            begin
                if (merge_active)
                    for (int i = 0; i < merge_lists; i++)
                        if (read_pos[i] < list_len[i] && (best < 0 ||
                            list_store[i][read_pos[i]] < list_store[best][read_pos[best]]))
                            best = i;
                if (best < 0)
                begin
                    if (merge_active)
                    begin
                        merge_active = 1'b0;
                        for (int i = 0; i < LISTS; i++)
                        begin
                            list_len[i] = 0;
                            read_pos[i] = 0;
                        end
                    end
                    r.status = ST_EXHAUSTED;
                end
                else
                begin
                    r.merged_value = list_store[best][read_pos[best]];
                    r.source_list = best[INDEX_W-1:0];
                    r.status = ST_VALID;
                    read_pos[best]++;
                end
                merged_expected = {merged_expected, r};
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                merge_step(command);
            if (!(start && busy))
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    start <= 1'b1;
                    command <= pending_items.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet_cycles++;
            if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            if (cfg_valid && cfg_ready)
                lists_cfg = cfg_data;
            if (result_valid)
            begin
                if (merged_expected.size() == 0)
                begin
                    report_mismatch("unexpected item", result, 0);
                end
                else
                begin
                    result_t want;
                    want = merged_expected.pop_front();
                    if (result.merged_value !== want.merged_value)
                        report_mismatch("merged_value", result.merged_value, want.merged_value);
                    if (result.source_list !== want.source_list)
                        report_mismatch("source_list", result.source_list, want.source_list);
                    if (result.status !== want.status)
                        report_mismatch("status", result.status, want.status);
                end
            end
            if (quiet_cycles > 20000)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    function automatic command_t make_item(input action_t a, input int idx,
                                           input logic [VALUE_W-1:0] v);
        command_t c;
        c.action = a;
        c.list_index = idx[INDEX_W-1:0];
        c.element_value = v;
        return c;
    endfunction

    task automatic add_merge();
        int total;
        int n;
        logic signed [VALUE_W-1:0] v;
        total = 0;
        for (int i = 0; i < LISTS; i++)
        begin
            n = $urandom_range(5);
            v = ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(20)) - 10;
            for (int k = 0; k < n; k++)
            begin
                queue_item(make_item(ACT_LOAD, i, v));
                v = ($urandom_range(7) == 0) ? $urandom : v + $urandom_range(3);
            end
            total += n;
        end
        if ($urandom_range(7) == 0)
            queue_item(make_item(ACT_POP, 0, $urandom));
        queue_item(make_item(ACT_START, $urandom, $urandom));
        if ($urandom_range(5) == 0)
        begin
            queue_item(make_item(ACT_POP, 0, 0));
            queue_item(make_item(ACT_LOAD, $urandom, $urandom));
            queue_item(make_item(ACT_START, 0, 0));
        end
        for (int k = 0; k <= total; k++)
        begin
            if ($urandom_range(9) == 0)
                queue_item(make_item(action_t'($urandom_range(3)), $urandom, $urandom));
            queue_item(make_item(ACT_POP, $urandom, $urandom));
        end
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || start || busy || merged_expected.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_lists(input logic [CFG_BITS-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [CFG_BITS-1:0] cfg_plan [6];
        cfg_plan = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        queue_item(make_item(ACT_POP, 0, 0));
        queue_item(make_item(ACT_NONE, 7, 32'hFFFF_FFFF));
        queue_item(make_item(ACT_LOAD, 0, 32'h8000_0000));
        queue_item(make_item(ACT_LOAD, 0, 32'h0000_0000));
        queue_item(make_item(ACT_LOAD, 1, 32'h7FFF_FFFF));
        queue_item(make_item(ACT_LOAD, 3, 32'h0000_0000));
        queue_item(make_item(ACT_LOAD, 7, 32'hFFFF_FFFF));
        queue_item(make_item(ACT_LOAD, 7, 32'h0000_0000));
        queue_item(make_item(ACT_START, 0, 0));
        queue_item(make_item(ACT_POP, 0, 0));
        queue_item(make_item(ACT_LOAD, 5, 32'h1234_5678));
        queue_item(make_item(ACT_POP, 0, 0));
        queue_item(make_item(ACT_START, 0, 0));
        for (int k = 0; k < 8; k++)
            queue_item(make_item(ACT_POP, 0, 0));
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            idle_pct = (ph < 2) ? 26 : (ph < 4) ? 48 : 0;
            write_lists(cfg_plan[ph]);
            for (int m = 0; m < ((ph < 2) ? 2 : 1); m++)
                add_merge();
            drain();
        end

        write_lists(4'd3);
        idle_pct = 0;
        for (int k = 0; k <= DEPTH; k++)
            queue_item(make_item(ACT_LOAD, 2, k * 3 - 300));
        queue_item(make_item(ACT_START, 0, 0));
        for (int k = 0; k < 12; k++)
            queue_item(make_item(ACT_POP, 0, 0));
        drain();

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

@@ sim.f @@
design/kwhm_pkg.sv
design/kwhm_ctrl.sv
design/kwhm_datapath.sv
design/k_way_heap_merge_unit.sv
design/kwhm_checker.sv
tb/tb_k_way_heap_merge_unit.sv
